### design/tcc_pkg.sv
package tcc_pkg;

   // stream payload widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int POS_W      = 11;

   // configuration port
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 4;
   localparam logic [CSR_ADDR_W-1:0] CSR_FORE_COLOUR = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BACK_COLOUR = 1'b1;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_READ  = 2'd1,
      MODE_MOVE  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   // control characters and the blank
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BLANK = 8'h20;

   localparam logic [3:0] RESET_FORE = 4'd7;
   localparam logic [3:0] RESET_BACK = 4'd0;
   localparam logic [15:0] RESET_CELL = {RESET_BACK, RESET_FORE, CH_BLANK};

endpackage

### design/tcc_ram.sv
module tcc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### design/text_console_cursor_engine_top.sv
// one word in flight; the next word is taken the cycle after its result is loaded
// plain byte or backspace: ST_EDIT then ST_FIN; cursor move: ST_ADDR then ST_FIN; read: ST_ADDR, ST_READ, ST_FIN
// newline, carriage return, tab: ST_MOD, ST_EDIT, ST_FIN; one reciprocal multiply gives the row or tab quotient
// clear: every cell blanked in ST_FILL through the single ram write port, then ST_FIN
// scroll adds ST_SHIFT and ST_FILL (row move one cell a cycle, then last row blanked)
// reset: synchronous; a clearing pass over all ROWS*COLUMNS cells runs first, req_tready stays low
module text_console_cursor_engine_top #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STEP = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // char_code[7:0], row[12:8], col[19:13], zero pad
   input  logic [tcc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode[1:0]
   input  logic [tcc_pkg::REQ_USER_W-1:0]   req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // cell_char[7:0], cell_attr[15:8], cursor_pos[26:16], scrolled[27], zero pad
   output logic [tcc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [tcc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [tcc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tcc_pkg::*;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int MOVE_N     = (ROWS - 1) * COLUMNS;
   localparam int CUR_W      = $clog2(CELL_COUNT);
   localparam int NXT_W      = CUR_W + 1;
   localparam int DIVMAX     = (COLUMNS > TAB_STEP) ? COLUMNS : TAB_STEP;
   localparam int REM_W      = $clog2(DIVMAX) + 1;
   localparam int PROD_W     = 5 + $clog2(COLUMNS + 1) + 1;
   localparam int SUM_W      = (PROD_W > CUR_W) ? PROD_W : CUR_W;
   // reciprocals exact for every cursor value below 2**CUR_W
   localparam int REC_SH     = CUR_W + $clog2(DIVMAX);
   localparam int REC_W      = REC_SH + 1;
   localparam int QPRD_W     = CUR_W + REC_W;
   localparam int REC_COL    = ((1 << REC_SH) + COLUMNS - 1) / COLUMNS;
   localparam int REC_TAB    = ((1 << REC_SH) + TAB_STEP - 1) / TAB_STEP;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_MOD, ST_EDIT, ST_SHIFT, ST_FILL, ST_ADDR, ST_READ, ST_FIN
   } state_type;

   state_type               state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic [7:0]              char_ff, char_in;
   logic [4:0]              row_ff, row_in;
   logic [6:0]              col_ff, col_in;
   logic [3:0]              fore_ff, fore_in;
   logic [3:0]              back_ff, back_in;
   logic [CUR_W-1:0]        cursor_ff, cursor_in;
   logic [NXT_W-1:0]        quo_ff, quo_in;
   logic [CUR_W-1:0]        swp_ff, swp_in;
   logic [CUR_W-1:0]        addr_ff, addr_in;
   logic                    scroll_ff, scroll_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                    ram_wr_en;
   logic [CUR_W-1:0]        ram_wr_addr;
   logic [15:0]             ram_wr_data;
   logic                    ram_rd_en;
   logic [CUR_W-1:0]        ram_rd_addr;
   logic [15:0]             ram_rd_data;

   logic [7:0]              req_char;
   logic                    req_ctl;
   logic [REM_W-1:0]        div_val;
   logic [REC_W-1:0]        rec_val;
   logic [QPRD_W-1:0]       quo_prod;
   logic [NXT_W-1:0]        nxt_val;
   logic [SUM_W-1:0]        lin_addr;
   logic                    in_rng;
   logic                    rd_hit;
   logic [15:0]             blank_cell;
   logic [CUR_W+POS_W-1:0]  pos_wide;

   tcc_ram #(
      .WIDTH(16),
      .DEPTH(CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_char   = req_tdata[7:0];
   assign req_ctl    = (req_char == CH_TAB) || (req_char == CH_LF) || (req_char == CH_CR);
   assign div_val    = (char_ff == CH_TAB) ? REM_W'(TAB_STEP) : REM_W'(COLUMNS);
   assign rec_val    = (char_ff == CH_TAB) ? REC_W'(REC_TAB) : REC_W'(REC_COL);
   assign quo_prod   = QPRD_W'(cursor_ff) * QPRD_W'(rec_val);
   assign lin_addr   = SUM_W'(row_ff) * SUM_W'(COLUMNS) + SUM_W'(col_ff);
   assign in_rng     = (int'(row_ff) < ROWS) && (int'(col_ff) < COLUMNS);
   assign rd_hit     = (mode_ff == MODE_READ) && in_rng;
   assign blank_cell = {back_ff, fore_ff, CH_BLANK};
   assign pos_wide   = {{POS_W{1'b0}}, cursor_ff};

   // candidate cursor once a put has been applied
   always_comb begin
      unique case (char_ff)
         CH_LF, CH_CR, CH_TAB: nxt_val = quo_ff * NXT_W'(div_val);
         CH_BS:   nxt_val = (cursor_ff != '0) ? NXT_W'(cursor_ff) - NXT_W'(1)
                                               : NXT_W'(cursor_ff);
         default: nxt_val = NXT_W'(cursor_ff) + NXT_W'(1);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      char_in      = char_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cursor_in    = cursor_ff;
      quo_in       = quo_ff;
      swp_in       = swp_ff;
      addr_in      = addr_ff;
      scroll_in    = scroll_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      fore_in      = fore_ff;
      back_in      = back_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = swp_ff;
      ram_wr_data  = blank_cell;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff;

      if (csr_we) begin
         unique case (csr_addr)
            CSR_FORE_COLOUR: fore_in = csr_wdata;
            CSR_BACK_COLOUR: back_in = csr_wdata;
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = RESET_CELL;
            if (swp_ff == CUR_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               swp_in = swp_ff + CUR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in   = mode_type'(req_tuser);
               char_in   = req_char;
               row_in    = req_tdata[12:8];
               col_in    = req_tdata[19:13];
               scroll_in = 1'b0;
               unique case (mode_type'(req_tuser))
                  MODE_PUT:             state_in = req_ctl ? ST_MOD : ST_EDIT;
                  MODE_READ, MODE_MOVE: state_in = ST_ADDR;
                  MODE_CLEAR: begin
                     cursor_in = '0;
                     swp_in    = '0;
                     state_in  = ST_FILL;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MOD: begin
            // row or tab quotient; newline and tab step on to the next multiple
            quo_in   = {1'b0, quo_prod[REC_SH +: CUR_W]} + NXT_W'(char_ff != CH_CR);
            state_in = ST_EDIT;
         end
         ST_EDIT: begin
            if (char_ff == CH_BS) begin
               ram_wr_en   = (cursor_ff != '0);
               ram_wr_addr = cursor_ff - CUR_W'(1);
            end else if (!((char_ff == CH_TAB) || (char_ff == CH_LF) || (char_ff == CH_CR))) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cursor_ff;
               ram_wr_data = {back_ff, fore_ff, char_ff};
            end
            if (nxt_val >= NXT_W'(CELL_COUNT)) begin
               scroll_in = 1'b1;
               swp_in    = '0;
               state_in  = ST_SHIFT;
            end else begin
               cursor_in = nxt_val[CUR_W-1:0];
               state_in  = ST_FIN;
            end
         end
         ST_SHIFT: begin
            // read one row ahead, write the word fetched last cycle one slot back
            ram_rd_en   = (swp_ff != CUR_W'(MOVE_N));
            ram_rd_addr = swp_ff + CUR_W'(COLUMNS);
            ram_wr_en   = (swp_ff != '0);
            ram_wr_addr = swp_ff - CUR_W'(1);
            ram_wr_data = ram_rd_data;
            if (swp_ff == CUR_W'(MOVE_N)) begin
               cursor_in = CUR_W'(MOVE_N);
               state_in  = ST_FILL;
            end else begin
               swp_in = swp_ff + CUR_W'(1);
            end
         end
         ST_FILL: begin
            ram_wr_en = 1'b1;
            if (swp_ff == CUR_W'(CELL_COUNT - 1)) begin
               state_in = ST_FIN;
            end else begin
               swp_in = swp_ff + CUR_W'(1);
            end
         end
         ST_ADDR: begin
            addr_in = lin_addr[CUR_W-1:0];
            if ((mode_ff == MODE_MOVE) && in_rng) begin
               cursor_in = lin_addr[CUR_W-1:0];
            end
            state_in = (mode_ff == MODE_READ) ? ST_READ : ST_FIN;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, scroll_ff, pos_wide[POS_W-1:0],
                               rd_hit ? ram_rd_data : 16'h0000};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         swp_ff       <= '0;
         cursor_ff    <= '0;
         fore_ff      <= RESET_FORE;
         back_ff      <= RESET_BACK;
         rsp_valid_ff <= 1'b0;
         scroll_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         swp_ff       <= swp_in;
         cursor_ff    <= cursor_in;
         fore_ff      <= fore_in;
         back_ff      <= back_in;
         rsp_valid_ff <= rsp_valid_in;
         scroll_ff    <= scroll_in;
      end
      mode_ff     <= mode_in;
      char_ff     <= char_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      quo_ff      <= quo_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_cursor_in_store: assert property (@(posedge clock) disable iff (reset)
      int'(cursor_ff) < CELL_COUNT)
      else $error("cursor beyond the cell store");

   a_one_word_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word accepted while the previous one is still at work");

   a_scroll_lands_last_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27] |-> rsp_tdata[26:16] == POS_W'(MOVE_N))
      else $error("scrolled result without the cursor at the last row start");

endmodule
